// File: sv/uvi_pkg.sv
// ----------------------------------------------------------------------------
// Unique value indexer package
// Shared constants, item types and the match-key function.
// ----------------------------------------------------------------------------
package uvi_pkg;

    // Default table depth and fixed field widths.
    localparam int UVI_MAX_UNIQUE = 256;
    localparam int VALUE_W        = 64;
    localparam int INDEX_W        = 8;
    localparam int F32_W          = 32;

    // Input item.
    typedef struct packed {
        logic [VALUE_W-1:0] value_in;
        logic               last_in;
    } t_uvi_in;

    // Result item.
    typedef struct packed {
        logic [INDEX_W-1:0] index_out;
        logic               is_new;
        logic [VALUE_W-1:0] value_out;
        logic               overflow;
        logic               last_out;
    } t_uvi_out;

    // Comparison key of a value. In float mode only the low 32 bits count,
    // and plus and minus zero both map to zero.
    function automatic logic [VALUE_W-1:0] uvi_key(
        input logic [VALUE_W-1:0] value,
        input logic               float_mode
    );
        logic [VALUE_W-1:0] key;
        key = value;
        if (float_mode) begin
            key = {{(VALUE_W-F32_W){1'b0}}, value[F32_W-1:0]};
            if (value[F32_W-2:0] == '0) begin
                key = '0;
            end
        end
        return key;
    endfunction

endpackage

// File: sv/unique_value_indexer_unit.sv
// ----------------------------------------------------------------------------
// Unique value indexer
// Gives each tensor element the index of its value's first occurrence.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_ready | i_in_data  (t_uvi_in)
//  out     | output    | o_out_valid/ i_out_ready| o_out_data (t_uvi_out)
//  cfg     | input     | i_cfg_valid/ o_cfg_ready| i_cfg_data (float_mode)
//
//  The scan compares an item against the stored unique values one after
//  another, through the single table read port and the one comparator; a
//  hit ends the scan at its position, while a new value is compared against
//  all of them. A new item is accepted at the edge after the scan has handed
//  off its result. The output register holds a result while the output is
//  stalled; the next item may be scanned meanwhile. A mode write is taken
//  only while the scan is idle and no item is offered. Synchronous reset
//  empties the table count and clears float_mode; the table needs no
//  clearing pass.
// ----------------------------------------------------------------------------
module unique_value_indexer_unit
    import uvi_pkg::*;
#(
    parameter int MAX_UNIQUE = UVI_MAX_UNIQUE
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_uvi_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_uvi_out o_out_data,
    input  logic     i_cfg_valid,
    output logic     o_cfg_ready,
    input  logic     i_cfg_data
);

    logic     r_float_mode;
    logic     r_out_valid;
    t_uvi_out r_out_data;

    logic     w_idle;
    logic     w_res_valid;
    logic     w_res_ready;
    t_uvi_out w_res;

    // The scan engine takes a new item only when idle.
    assign o_in_ready = w_idle;

    uvi_scan #(
        .MAX_UNIQUE (MAX_UNIQUE)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_float_mode (r_float_mode),
        .i_start      (i_in_valid && w_idle),
        .i_item       (i_in_data),
        .o_idle       (w_idle),
        .o_res_valid  (w_res_valid),
        .i_res_ready  (w_res_ready),
        .o_res        (w_res)
    );

    // The mode changes only between scans, never beside an item being taken.
    assign o_cfg_ready = w_idle && !i_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_float_mode <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_float_mode <= i_cfg_data;
        end
    end

    // Output register decouples the scan from a stalled consumer.
    assign w_res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
        if (w_res_ready && w_res_valid) begin
            r_out_data <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: sv/uvi_scan.sv
// ----------------------------------------------------------------------------
// Unique value indexer table scan
// Holds the value table and walks it with one comparator per item.
// ----------------------------------------------------------------------------
module uvi_scan
    import uvi_pkg::*;
#(
    parameter int MAX_UNIQUE = UVI_MAX_UNIQUE
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_float_mode,
    input  logic     i_start,
    input  t_uvi_in  i_item,
    output logic     o_idle,
    output logic     o_res_valid,
    input  logic     i_res_ready,
    output t_uvi_out o_res
);

    localparam int ADDR_W = (MAX_UNIQUE > 1) ? $clog2(MAX_UNIQUE) : 1;
    localparam int CNT_W  = $clog2(MAX_UNIQUE + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_rd_addr, n_rd_addr;
    logic                r_rd_vld, n_rd_vld;
    logic [ADDR_W-1:0]   r_rd_idx, n_rd_idx;
    logic [VALUE_W-1:0]  r_value, n_value;
    logic [VALUE_W-1:0]  r_key, n_key;
    logic                r_last, n_last;
    t_uvi_out            r_res, n_res;

    logic [VALUE_W-1:0]  r_rd_data;
    logic [VALUE_W-1:0]  r_table [MAX_UNIQUE];

    logic                w_issue;
    logic                w_hit;
    logic                w_miss;
    logic                w_full;
    logic                w_wr_en;
    logic [CNT_W-1:0]    w_pos;
    logic [CNT_W+INDEX_W-1:0] w_pos_ext;

    // Scan control: one table read issued and one entry compared per cycle.
    assign w_issue = (r_state == S_SCAN) && (r_rd_addr < r_count);
    assign w_hit   = (r_state == S_SCAN) && r_rd_vld
                     && (uvi_key(r_rd_data, i_float_mode) == r_key);
    assign w_miss  = (r_state == S_SCAN) && !w_hit && (r_rd_addr >= r_count);
    assign w_full  = (r_count == CNT_W'(MAX_UNIQUE));
    assign w_wr_en = w_miss && !w_full;

    // Position reported in the result, cut to the index field width.
    always_comb begin
        if (w_hit) begin
            w_pos = CNT_W'(r_rd_idx);
        end else if (w_full) begin
            w_pos = '0;
        end else begin
            w_pos = r_count;
        end
        w_pos_ext = {{INDEX_W{1'b0}}, w_pos};
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_rd_addr = r_rd_addr;
        n_rd_vld  = r_rd_vld;
        n_rd_idx  = r_rd_idx;
        n_value   = r_value;
        n_key     = r_key;
        n_last    = r_last;
        n_res     = r_res;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state   = S_SCAN;
                    n_value   = i_item.value_in;
                    n_key     = uvi_key(i_item.value_in, i_float_mode);
                    n_last    = i_item.last_in;
                    n_rd_addr = '0;
                    n_rd_vld  = 1'b0;
                end
            end
            S_SCAN: begin
                n_rd_vld  = w_issue;
                n_rd_idx  = r_rd_addr[ADDR_W-1:0];
                if (w_issue) begin
                    n_rd_addr = r_rd_addr + CNT_W'(1);
                end
                if (w_hit || w_miss) begin
                    n_state         = S_DONE;
                    n_res.index_out = w_pos_ext[INDEX_W-1:0];
                    n_res.is_new    = w_wr_en;
                    n_res.value_out = r_value;
                    n_res.overflow  = w_miss && w_full;
                    n_res.last_out  = r_last;
                    if (r_last) begin
                        n_count = '0;
                    end else if (w_wr_en) begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_vld <= n_rd_vld;
        end
        r_rd_addr <= n_rd_addr;
        r_rd_idx  <= n_rd_idx;
        r_value   <= n_value;
        r_key     <= n_key;
        r_last    <= n_last;
        r_res     <= n_res;
    end

    // Value table: one write port for new values, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_table[r_count[ADDR_W-1:0]] <= r_value;
        end
        if (w_issue) begin
            r_rd_data <= r_table[r_rd_addr[ADDR_W-1:0]];
        end
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

// File: sv/uvi_checker.sv
// ----------------------------------------------------------------------------
// Unique value indexer checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module uvi_checker
    import uvi_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_ready,
    input t_uvi_in  i_in_data,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_uvi_out o_out_data,
    input logic     i_cfg_valid,
    input logic     o_cfg_ready,
    input logic     i_cfg_data
);

    // A stalled result item stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result item changed while stalled");

    // An accepted item keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after an accepted item");

    // An overflow result never claims a new entry and reports index zero.
    a_overflow_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.overflow |->
            !o_out_data.is_new && (o_out_data.index_out == '0))
        else $error("overflow result with bad index or new flag");

    // Reset leaves no result pending and the input ready.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not idle after reset");

endmodule

bind unique_value_indexer_unit uvi_checker u_uvi_checker (.*);
